### src/waveform_peak_detector_core_macros.svh
// Assertion macros for the waveform peak detector core.
`ifndef WAVEFORM_PEAK_DETECTOR_CORE_MACROS_SVH
`define WAVEFORM_PEAK_DETECTOR_CORE_MACROS_SVH

`ifndef SYNTH

// Antecedent implies consequent in the same cycle, outside reset.
`define WPD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle, outside reset.
`define WPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define WPD_ASSERT_IMPL(lbl, ante, cons)
`define WPD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### src/wpd_pkg.sv
// Shared constants, types and register codes of the waveform peak detector.
package wpd_pkg;

  localparam int AMP_BITS      = 12;
  localparam int TIME_BITS     = 16;
  localparam int DIFF_BITS     = AMP_BITS + 2;
  localparam int THR_BITS      = 13;
  localparam int SPC_CFG_BITS  = 16;
  localparam int CMP_BITS      = ((DIFF_BITS > THR_BITS + 1) ? DIFF_BITS : THR_BITS + 1) + 1;
  localparam int SPC_BITS      = ((TIME_BITS > SPC_CFG_BITS) ? TIME_BITS : SPC_CFG_BITS) + 2;
  localparam int CFG_IDX_BITS  = 4;
  localparam int CFG_DATA_BITS = 16;

  typedef logic [AMP_BITS-1:0]         amp_t;
  typedef logic [TIME_BITS-1:0]        time_t;
  typedef logic signed [DIFF_BITS-1:0] diff_t;
  typedef logic [THR_BITS-1:0]         thr_t;
  typedef logic [SPC_CFG_BITS-1:0]     spc_t;
  typedef logic [CFG_IDX_BITS-1:0]     cfg_idx_t;
  typedef logic [CFG_DATA_BITS-1:0]    cfg_data_t;
  typedef logic [1:0]                  seen_t;

  localparam cfg_idx_t CFG_FINISH_THRESHOLD = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_MIN_SPACING      = cfg_idx_t'(1);

  localparam thr_t  FINISH_THRESHOLD_RST = thr_t'(2);
  localparam spc_t  MIN_SPACING_RST      = spc_t'(4);
  localparam seen_t WIN_FULL             = seen_t'(2);

  typedef struct packed {
    thr_t finish_threshold;
    spc_t min_spacing;
  } cfg_t;

  typedef struct packed {
    time_t sample_time;
    amp_t  amplitude;
    amp_t  noise_floor;
    logic  last_sample;
  } item_t;

  typedef struct packed {
    logic  peak_found;
    amp_t  peak_amplitude;
    time_t peak_time;
    logic  waveform_done;
  } result_t;

  typedef struct packed {
    amp_t  win_amp0;
    amp_t  win_amp1;
    time_t win_time0;
    time_t win_time1;
    seen_t samples_seen;
    logic  tracking;
    diff_t min_second_diff;
    amp_t  cand_amp;
    time_t cand_time;
    logic  have_prior;
    time_t prior_time;
  } state_t;

endpackage

### src/wpd_ifs.sv
// Channel interfaces: sample input, peak result output and register writes.
interface wpd_in_if;
  logic                 valid;
  logic                 ready;
  wpd_pkg::time_t       sample_time;
  wpd_pkg::amp_t        amplitude;
  wpd_pkg::amp_t        noise_floor;
  logic                 last_sample;
  modport source (output valid, sample_time, amplitude, noise_floor, last_sample,
                  input ready);
  modport sink   (input valid, sample_time, amplitude, noise_floor, last_sample,
                  output ready);
endinterface

interface wpd_out_if;
  logic                 valid;
  logic                 ready;
  logic                 peak_found;
  wpd_pkg::amp_t        peak_amplitude;
  wpd_pkg::time_t       peak_time;
  logic                 waveform_done;
  modport source (output valid, peak_found, peak_amplitude, peak_time, waveform_done,
                  input ready);
  modport sink   (input valid, peak_found, peak_amplitude, peak_time, waveform_done,
                  output ready);
endinterface

interface wpd_cfg_if;
  logic                 valid;
  logic                 ready;
  wpd_pkg::cfg_idx_t    index;
  wpd_pkg::cfg_data_t   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### src/wpd_cfg_regs.sv
// Configuration registers: finish threshold and minimum peak spacing.
module wpd_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  wpd_pkg::cfg_idx_t  wr_index,
  input  wpd_pkg::cfg_data_t wr_data,
  output wpd_pkg::cfg_t      cfg
);

  wpd_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.finish_threshold <= wpd_pkg::FINISH_THRESHOLD_RST;
      cfg_r.min_spacing      <= wpd_pkg::MIN_SPACING_RST;
    end else if (wr_en) begin
      case (wr_index)
        wpd_pkg::CFG_FINISH_THRESHOLD: begin
          cfg_r.finish_threshold <= wr_data[wpd_pkg::THR_BITS-1:0];
        end
        wpd_pkg::CFG_MIN_SPACING: begin
          cfg_r.min_spacing <= wr_data[wpd_pkg::SPC_CFG_BITS-1:0];
        end
        default: begin
          // unknown index: write dropped
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### src/wpd_step.sv
// One-sample update: second difference, peak tracking and report decision.
module wpd_step (
  input  wpd_pkg::state_t  state,
  input  wpd_pkg::item_t   item,
  input  wpd_pkg::cfg_t    cfg,
  output wpd_pkg::state_t  state_nxt,
  output wpd_pkg::result_t result
);

  localparam int TB  = wpd_pkg::TIME_BITS;
  localparam int CB  = wpd_pkg::CMP_BITS;
  localparam int SB  = wpd_pkg::SPC_BITS;

  wpd_pkg::diff_t        d_raw;
  wpd_pkg::diff_t        d_eff;
  logic [TB:0]           t0_inc;
  logic [TB:0]           t1_inc;
  logic                  gap;
  logic                  full;
  logic signed [CB-1:0]  d_cmp;
  logic signed [CB-1:0]  thr_cmp;
  logic                  fin;
  logic                  neg;
  logic                  replace;
  logic                  track_after;
  logic                  offer;
  logic                  loud;
  logic signed [SB-1:0]  sp_a;
  logic signed [SB-1:0]  sp_b;
  logic signed [SB-1:0]  sp_diff;
  logic signed [SB-1:0]  sp_min;
  logic                  too_close;
  logic                  report;
  wpd_pkg::state_t       upd;

  always_comb begin
    d_raw = wpd_pkg::diff_t'({2'b00, state.win_amp0})
          - wpd_pkg::diff_t'({1'b0, state.win_amp1, 1'b0})
          + wpd_pkg::diff_t'({2'b00, item.amplitude});

    t0_inc = {1'b0, state.win_time0} + {{TB{1'b0}}, 1'b1};
    t1_inc = {1'b0, state.win_time1} + {{TB{1'b0}}, 1'b1};
    gap    = ({1'b0, state.win_time1} != t0_inc) || ({1'b0, item.sample_time} != t1_inc);
    full   = (state.samples_seen == wpd_pkg::WIN_FULL);
    d_eff  = gap ? '0 : d_raw;

    d_cmp   = CB'(d_eff);
    thr_cmp = CB'({1'b0, cfg.finish_threshold});

    fin     = full && state.tracking && !gap && (d_cmp >= thr_cmp);
    neg     = full && !fin && d_eff[wpd_pkg::DIFF_BITS-1];
    replace = neg && ((d_eff < state.min_second_diff) || (state.win_amp1 > state.cand_amp));

    if (fin) begin
      track_after = 1'b0;
    end else if (neg) begin
      track_after = 1'b1;
    end else if (full && gap) begin
      track_after = 1'b0;
    end else begin
      track_after = state.tracking;
    end

    upd                 = state;
    upd.tracking        = track_after;
    if (fin) begin
      upd.min_second_diff = '0;
    end else if (replace) begin
      upd.min_second_diff = d_eff;
      upd.cand_amp        = state.win_amp1;
      upd.cand_time       = state.win_time1;
    end
    upd.win_amp0  = state.win_amp1;
    upd.win_time0 = state.win_time1;
    upd.win_amp1  = item.amplitude;
    upd.win_time1 = item.sample_time;
    if (!full) begin
      upd.samples_seen = state.samples_seen + wpd_pkg::seen_t'(1);
    end

    // at most one offer per sample: a closing peak clears tracking
    offer     = fin || (item.last_sample && track_after);
    loud      = upd.cand_amp > item.noise_floor;
    sp_a      = SB'({1'b0, upd.cand_time});
    sp_b      = SB'({1'b0, state.prior_time});
    sp_diff   = sp_a - sp_b;
    sp_min    = SB'({1'b0, cfg.min_spacing});
    too_close = state.have_prior && (sp_diff < sp_min);
    report    = offer && loud && !too_close;

    if (offer && loud) begin
      upd.have_prior = 1'b1;
      upd.prior_time = upd.cand_time;
    end

    state_nxt = item.last_sample ? '0 : upd;

    result.peak_found     = report;
    result.peak_amplitude = report ? upd.cand_amp : '0;
    result.peak_time      = report ? upd.cand_time : '0;
    result.waveform_done  = item.last_sample;
  end

endmodule

### src/waveform_peak_detector_core.sv
// Top level of the waveform peak detector core.
//
// Usage:
//   in_chan  (sink)   : one sample per transaction: sample_time, amplitude,
//                       noise_floor, last_sample.
//   out_chan (source) : exactly one result transaction per sample, in order:
//                       peak_found, peak_amplitude, peak_time, waveform_done.
//   cfg_chan (sink)   : register writes, index 0 = finish_threshold,
//                       index 1 = min_spacing; other indexes are dropped.
//                       Always ready; write only while the core is idle.
// Path: a sample accepted into the input register passes the state update
//   and its result is registered in the result register, then offered on out_chan.
// Throughput: one sample per cycle while out_chan is not stalled, set by the
//   combinational state update between the input register and the result register.
// Reset (rst_n low, synchronous): both stages empty, detector state zeroed,
//   finish_threshold = 2, min_spacing = 4.
// Stall: while out_chan is held off the result register keeps its
//   transaction; one more sample is taken into the input register, after which
//   in_chan.ready drops until the result is taken.
// After a last_sample transaction detector state returns to reset; registers kept.
`include "waveform_peak_detector_core_macros.svh"

module waveform_peak_detector_core (
  input  logic      clk,
  input  logic      rst_n,
  wpd_in_if.sink    in_chan,
  wpd_out_if.source out_chan,
  wpd_cfg_if.sink   cfg_chan
);

  wpd_pkg::cfg_t    cfg;
  wpd_pkg::item_t   in_r;
  logic             in_valid_r;
  wpd_pkg::state_t  state_r;
  wpd_pkg::state_t  state_nxt;
  wpd_pkg::result_t out_r;
  wpd_pkg::result_t out_nxt;
  logic             out_valid_r;
  logic             advance;
  logic             in_take;

  // register file; writes are registered
  assign cfg_chan.ready = 1'b1;

  wpd_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_chan.valid),
    .wr_index (cfg_chan.index),
    .wr_data  (cfg_chan.data),
    .cfg      (cfg)
  );

  // per-sample update, fully combinational between in_r and out_r
  wpd_step u_step (
    .state     (state_r),
    .item      (in_r),
    .cfg       (cfg),
    .state_nxt (state_nxt),
    .result    (out_nxt)
  );

  // input stage moves on when the result register is free or draining
  assign advance       = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || advance;
  assign in_take       = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end

      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r.sample_time <= in_chan.sample_time;
      in_r.amplitude   <= in_chan.amplitude;
      in_r.noise_floor <= in_chan.noise_floor;
      in_r.last_sample <= in_chan.last_sample;
    end
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.peak_found     = out_r.peak_found;
  assign out_chan.peak_amplitude = out_r.peak_amplitude;
  assign out_chan.peak_time      = out_r.peak_time;
  assign out_chan.waveform_done  = out_r.waveform_done;

  // a full input stage behind a stalled result must hold off the source
  `WPD_ASSERT_IMPL(a_hold_in, in_valid_r && out_valid_r && !out_chan.ready, !in_chan.ready)
  // a result without a peak carries zero amplitude and time
  `WPD_ASSERT_IMPL(a_zero_payload, out_valid_r && !out_r.peak_found,
                   out_r.peak_amplitude == '0 && out_r.peak_time == '0)
  // the last sample of a waveform leaves the detector state cleared
  `WPD_ASSERT_NEXT(a_clear_on_last, advance && in_r.last_sample,
                   state_r.samples_seen == '0 && !state_r.tracking && !state_r.have_prior)

endmodule

### dv/testbench.sv
// Self-checking testbench for the waveform peak detector core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 12;
  localparam int DRAIN_CYCLES = 4;       // two-stage pipe plus margin
  localparam int RANDOM_ITEMS = 1700;
  localparam int PHASE_ITEMS  = 200;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int AMP_TOP      = (1 << wpd_pkg::AMP_BITS) - 1;
  localparam int THR_TOP      = 8190;
  localparam int SPC_TOP      = 65535;

  // highest register index; nothing is mapped there
  localparam wpd_pkg::cfg_idx_t CFG_IDX_TOP = '1;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;
  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PULSE} rx_mode_t;

  // One line of the directed table. Sample rows carry an optional hand-typed
  // result; write rows carry a register index and value.
  typedef struct {
    row_kind_t          kind;
    wpd_pkg::time_t     t;
    wpd_pkg::amp_t      a;
    wpd_pkg::amp_t      noise;
    logic               last;
    logic               typed;
    logic               found;
    wpd_pkg::amp_t      pamp;
    wpd_pkg::time_t     ptime;
    logic               done;
    wpd_pkg::cfg_idx_t  idx;
    wpd_pkg::cfg_data_t data;
  } stim_row_t;

  localparam int N_DIRECTED = 34;

  // Directed table. Typed results only where they are obvious by hand:
  // fresh after reset, a full-scale peak, spacing suppression, noise drop
  // at full scale. Everything else goes through the predictor.
  stim_row_t directed_rows [N_DIRECTED] = '{
    // short waveform right after reset: no window yet
    '{ROW_SAMPLE,     0,    0,    0, 0, 1, 0,    0,  0, 0, '0, '0},
    '{ROW_SAMPLE,     1, 4095, 4095, 1, 1, 0,    0,  0, 1, '0, '0},
    // full-scale spike, closed by a large difference
    '{ROW_SAMPLE,    10,    0,    0, 0, 0, 0,    0,  0, 0, '0, '0},
    '{ROW_SAMPLE,    11, 4095,    0, 0, 0, 0,    0,  0, 0, '0, '0},
    '{ROW_SAMPLE,    12,    0,    0, 0, 0, 0,    0,  0, 0, '0, '0},
    '{ROW_SAMPLE,    13,    0,    0, 0, 1, 1, 4095, 11, 0, '0, '0},
    // second spike 3 ticks after the first: suppressed by min_spacing 4
    '{ROW_SAMPLE,    14, 4095,    0, 0, 0, 0,    0,  0, 0, '0, '0},
    '{ROW_SAMPLE,    15,    0,    0, 0, 0, 0,    0,  0, 0, '0, '0},
    '{ROW_SAMPLE,    16,    0,    0, 0, 1, 0,    0,  0, 0, '0, '0},
    // third spike at full scale noise: dropped, waveform ends
    '{ROW_SAMPLE,    17, 4095,    0, 0, 0, 0,    0,  0, 0, '0, '0},
    '{ROW_SAMPLE,    18,    0,    0, 0, 0, 0,    0,  0, 0, '0, '0},
    '{ROW_SAMPLE,    19, 4095, 4095, 1, 1, 0,    0,  0, 1, '0, '0},
    // time index wraps to 0 (a gap), then a peak still open at the end
    '{ROW_SAMPLE, 65534,  100,   50, 0, 0, 0,    0,  0, 0, '0, '0},
    '{ROW_SAMPLE, 65535,  200,   50, 0, 0, 0,    0,  0, 0, '0, '0},
    '{ROW_SAMPLE,     0,  100,   50, 0, 0, 0,    0,  0, 0, '0, '0},
    '{ROW_SAMPLE,     1,   50,   50, 0, 0, 0,    0,  0, 0, '0, '0},
    '{ROW_SAMPLE,     2,  200,   50, 0, 0, 0,    0,  0, 0, '0, '0},
    '{ROW_SAMPLE,     3,  300,   50, 0, 0, 0,    0,  0, 0, '0, '0},
    '{ROW_SAMPLE,     4,  400,   50, 0, 0, 0,    0,  0, 0, '0, '0},
    '{ROW_SAMPLE,     5,  300,    0, 1, 0, 0,    0,  0, 0, '0, '0},
    // lowest settings, plus a write to an unmapped index
    '{ROW_WRITE, 0, 0, 0, 0, 0, 0, 0, 0, 0, wpd_pkg::CFG_FINISH_THRESHOLD, 16'd0},
    '{ROW_WRITE, 0, 0, 0, 0, 0, 0, 0, 0, 0, wpd_pkg::CFG_MIN_SPACING, 16'd0},
    '{ROW_WRITE, 0, 0, 0, 0, 0, 0, 0, 0, 0, CFG_IDX_TOP, 16'hFFFF},
    '{ROW_SAMPLE,   100,   10,    0, 0, 0, 0,    0,  0, 0, '0, '0},
    '{ROW_SAMPLE,   101,   20,    0, 0, 0, 0,    0,  0, 0, '0, '0},
    '{ROW_SAMPLE,   102,   10,    0, 0, 0, 0,    0,  0, 0, '0, '0},
    '{ROW_SAMPLE,   103,   10,    0, 0, 0, 0,    0,  0, 0, '0, '0},
    '{ROW_SAMPLE,   109,    0,    0, 1, 0, 0,    0,  0, 0, '0, '0},
    // highest spacing, threshold at the largest second difference
    '{ROW_WRITE, 0, 0, 0, 0, 0, 0, 0, 0, 0, wpd_pkg::CFG_FINISH_THRESHOLD, 16'd8190},
    '{ROW_WRITE, 0, 0, 0, 0, 0, 0, 0, 0, 0, wpd_pkg::CFG_MIN_SPACING, 16'hFFFF},
    '{ROW_SAMPLE,   200,    0,    0, 0, 0, 0,    0,  0, 0, '0, '0},
    '{ROW_SAMPLE,   201, 4095,    0, 0, 0, 0,    0,  0, 0, '0, '0},
    '{ROW_SAMPLE,   202,    0,    0, 0, 0, 0,    0,  0, 0, '0, '0},
    '{ROW_SAMPLE,   203, 4095,    0, 1, 0, 0,    0,  0, 0, '0, '0}
  };

  logic clk;
  logic rst_n;

  wpd_in_if  in_if ();
  wpd_out_if out_if ();
  wpd_cfg_if cfg_if ();

  waveform_peak_detector_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Detector predictor: own copy of the registers and the sample window.
  // ---------------------------------------------------------------------------
  wpd_pkg::thr_t  close_level;    // finish_threshold
  wpd_pkg::spc_t  spacing_min;    // min_spacing
  wpd_pkg::amp_t  win_amp [2];    // [0] oldest
  wpd_pkg::time_t win_tm  [2];
  wpd_pkg::seen_t fill;
  logic           tracking_on;
  wpd_pkg::diff_t deepest_dip;
  wpd_pkg::amp_t  cand_amp;
  wpd_pkg::time_t cand_tm;
  logic           prior_valid;
  wpd_pkg::time_t prior_tm;

  // results the core still owes, oldest first
  wpd_pkg::result_t peak_results_due [$];

  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned burst_left;
  logic        sender_steady;   // no gaps between sample transactions

  function automatic void clear_window();
    win_amp[0]  = '0;
    win_amp[1]  = '0;
    win_tm[0]   = '0;
    win_tm[1]   = '0;
    fill        = '0;
    tracking_on = 1'b0;
    deepest_dip = '0;
    cand_amp    = '0;
    cand_tm     = '0;
    prior_valid = 1'b0;
    prior_tm    = '0;
  endfunction

  // A closed peak: louder than noise counts and moves the prior time; it is
  // reported only if far enough after the prior one (signed distance).
  function automatic logic accept_peak(wpd_pkg::amp_t amp, wpd_pkg::time_t tm,
                                       wpd_pkg::amp_t noise);
    logic too_close;
    if (amp <= noise) return 1'b0;
    too_close   = prior_valid && (int'(tm) - int'(prior_tm) < int'(spacing_min));
    prior_valid = 1'b1;
    prior_tm    = tm;
    return !too_close;
  endfunction

  function automatic wpd_pkg::result_t track_sample(wpd_pkg::item_t smp);
    int               d2;
    logic             broken;
    logic             found;
    wpd_pkg::result_t res;
    found = 1'b0;
    res   = '0;
    if (fill >= wpd_pkg::WIN_FULL) begin
      d2 = int'(win_amp[0]) - 2 * int'(win_amp[1]) + int'(smp.amplitude);
      // any step other than +1 is a gap, including wrap to 0
      broken = (int'(win_tm[1]) != int'(win_tm[0]) + 1) ||
               (int'(smp.sample_time) != int'(win_tm[1]) + 1);
      if (broken) begin
        d2          = 0;
        tracking_on = 1'b0;   // candidate and dip kept as they are
      end
      if (d2 >= int'(close_level) && tracking_on) begin
        found       = accept_peak(cand_amp, cand_tm, smp.noise_floor);
        deepest_dip = '0;
        tracking_on = 1'b0;
      end else if (d2 < 0) begin
        tracking_on = 1'b1;
        if (d2 < int'(deepest_dip) || win_amp[1] > cand_amp) begin
          deepest_dip = wpd_pkg::diff_t'(d2);
          cand_amp    = win_amp[1];
          cand_tm     = win_tm[1];
        end
      end
    end
    win_amp[0] = win_amp[1];
    win_tm[0]  = win_tm[1];
    win_amp[1] = smp.amplitude;
    win_tm[1]  = smp.sample_time;
    if (fill < wpd_pkg::WIN_FULL) fill++;
    if (smp.last_sample) begin
      // peak still open at the end of the waveform
      if (tracking_on && !found) found = accept_peak(cand_amp, cand_tm, smp.noise_floor);
      if (found) begin
        res.peak_amplitude = cand_amp;
        res.peak_time      = cand_tm;
      end
      clear_window();
    end else if (found) begin
      res.peak_amplitude = cand_amp;
      res.peak_time      = cand_tm;
    end
    res.peak_found    = found;
    res.waveform_done = smp.last_sample;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. Inputs change on the falling edge; handshakes are seen on the
  // rising edge.
  // ---------------------------------------------------------------------------

  // Present one sample, hold it until the transaction completes, then maybe
  // idle between bursts. A typed result replaces the predicted one.
  task automatic send_sample(input wpd_pkg::item_t smp, input logic use_typed,
                             input wpd_pkg::result_t typed_res);
    wpd_pkg::result_t predicted;
    in_if.valid       = 1'b1;
    in_if.sample_time = smp.sample_time;
    in_if.amplitude   = smp.amplitude;
    in_if.noise_floor = smp.noise_floor;
    in_if.last_sample = smp.last_sample;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predicted = track_sample(smp);
    peak_results_due.insert(peak_results_due.size(), use_typed ? typed_res : predicted);
    items_sent++;
    @(negedge clk);
    if (!sender_steady) begin
      if (burst_left == 0) begin
        in_if.valid = 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        burst_left = $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Register write, only with the core drained.
  task automatic write_register(input wpd_pkg::cfg_idx_t idx, input wpd_pkg::cfg_data_t val);
    in_if.valid = 1'b0;
    while (peak_results_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      wpd_pkg::CFG_FINISH_THRESHOLD: close_level = wpd_pkg::thr_t'(val);
      wpd_pkg::CFG_MIN_SPACING:      spacing_min = wpd_pkg::spc_t'(val);
      default: ;            // unmapped index, dropped by the core
    endcase
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // One random waveform: a random walk whose slope turns now and then, so
  // dips in the second difference (peaks) show up often. A few waveforms are
  // scrambled noise, a few have time gaps, some run on without a last mark.
  task automatic play_waveform();
    wpd_pkg::item_t smp;
    int             len;
    int             amp;
    int             slope;
    int             step_max;
    int             noise;
    logic           scrambled;
    logic           open_end;
    wpd_pkg::time_t t;
    len       = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 48);
    scrambled = ($urandom_range(0, 9) == 0);
    open_end  = ($urandom_range(0, 9) == 0);
    t         = ($urandom_range(0, 7) == 0) ?
                wpd_pkg::time_t'(SPC_TOP - $urandom_range(0, 8)) :
                wpd_pkg::time_t'($urandom);
    amp       = $urandom_range(0, AMP_TOP);
    slope     = 0;
    case ($urandom_range(0, 3))
      0:       step_max = 3;
      1:       step_max = 40;
      2:       step_max = 500;
      default: step_max = AMP_TOP;
    endcase
    case ($urandom_range(0, 5))
      0:       noise = 0;
      1:       noise = AMP_TOP;
      2:       noise = $urandom_range(0, AMP_TOP);
      default: noise = $urandom_range(0, 2048);
    endcase
    for (int i = 0; i < len; i++) begin
      if (scrambled || $urandom_range(0, 39) == 0) begin
        case ($urandom_range(0, 3))
          0:       t = wpd_pkg::time_t'($urandom);
          1:       t = t - wpd_pkg::time_t'(1);     // repeats the previous index
          2:       t = t + wpd_pkg::time_t'(1);     // skips one index
          default: t = t - wpd_pkg::time_t'($urandom_range(2, 5));
        endcase
      end
      if (scrambled) begin
        amp = $urandom_range(0, AMP_TOP);
      end else begin
        if ($urandom_range(0, 2) == 0)
          slope = int'($urandom_range(0, 2 * step_max)) - step_max;
        amp = amp + slope;
        if (amp > AMP_TOP) begin
          amp   = AMP_TOP;
          slope = -slope;
        end else if (amp < 0) begin
          amp   = 0;
          slope = -slope;
        end
      end
      smp.sample_time = t;
      smp.amplitude   = wpd_pkg::amp_t'(amp);
      smp.noise_floor = ($urandom_range(0, 7) == 0) ? wpd_pkg::amp_t'($urandom)
                                                    : wpd_pkg::amp_t'(noise);
      smp.last_sample = (i == len - 1) && !open_end;
      send_sample(smp, 1'b0, '0);
      t = t + wpd_pkg::time_t'(1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: ready changes on the falling edge, following a mode that is
  // picked again when its random run ends (always open, light or heavy
  // random stalls, a regular stall pulse).
  // ---------------------------------------------------------------------------
  rx_mode_t    rx_mode;
  int unsigned rx_mode_left;

  initial begin
    out_if.ready = 1'b0;
    rx_mode      = RX_OPEN;
    rx_mode_left = 0;
  end

  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_t'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(8, 80);
    end else begin
      rx_mode_left--;
    end
    case (rx_mode)
      RX_OPEN:  out_if.ready <= 1'b1;
      RX_LIGHT: out_if.ready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY: out_if.ready <= ($urandom_range(0, 3) == 0);
      default:  out_if.ready <= (rx_mode_left % 4 != 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result check: every result transaction against the oldest one owed.
  // ---------------------------------------------------------------------------
  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    wpd_pkg::result_t want_res;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (peak_results_due.size() == 0) begin
        $error("result transaction with nothing outstanding");
        fail_count++;
      end else begin
        want_res = peak_results_due.pop_front();
        check_field("peak_found", want_res.peak_found, out_if.peak_found);
        check_field("peak_amplitude", want_res.peak_amplitude, out_if.peak_amplitude);
        check_field("peak_time", want_res.peak_time, out_if.peak_time);
        check_field("waveform_done", want_res.waveform_done, out_if.waveform_done);
      end
    end
  end

  // Hard stop if the run hangs.
  int unsigned cycle_count;
  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table, random phases, drain, verdict.
  // ---------------------------------------------------------------------------
  initial begin
    stim_row_t        row;
    wpd_pkg::item_t   smp;
    wpd_pkg::result_t typed_res;
    int               phase;
    int               thr_pick;
    int               spc_pick;
    int               phase_end;

    fail_count        = 0;
    items_sent        = 0;
    burst_left        = 0;
    sender_steady     = 1'b0;
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.sample_time = '0;
    in_if.amplitude   = '0;
    in_if.noise_floor = '0;
    in_if.last_sample = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = '0;
    cfg_if.data       = '0;

    close_level = wpd_pkg::FINISH_THRESHOLD_RST;
    spacing_min = wpd_pkg::MIN_SPACING_RST;
    clear_window();

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed table
    for (int i = 0; i < N_DIRECTED; i++) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) begin
        write_register(row.idx, row.data);
      end else begin
        smp.sample_time          = row.t;
        smp.amplitude            = row.a;
        smp.noise_floor          = row.noise;
        smp.last_sample          = row.last;
        typed_res.peak_found     = row.found;
        typed_res.peak_amplitude = row.pamp;
        typed_res.peak_time      = row.ptime;
        typed_res.waveform_done  = row.done;
        send_sample(smp, row.typed, typed_res);
      end
    end

    // random phases, each under its own register setting
    phase = 0;
    while (items_sent + PHASE_ITEMS <= N_DIRECTED + RANDOM_ITEMS) begin
      case (phase % 5)
        0: begin
          thr_pick = wpd_pkg::FINISH_THRESHOLD_RST;
          spc_pick = wpd_pkg::MIN_SPACING_RST;
        end
        1: begin
          thr_pick = 0;
          spc_pick = 0;
        end
        2: begin
          thr_pick = THR_TOP;
          spc_pick = SPC_TOP;
        end
        3: begin
          thr_pick = $urandom_range(0, 64);
          spc_pick = $urandom_range(0, 16);
        end
        default: begin
          thr_pick = $urandom_range(0, THR_TOP);
          spc_pick = $urandom_range(0, SPC_TOP);
        end
      endcase
      write_register(wpd_pkg::CFG_FINISH_THRESHOLD, wpd_pkg::cfg_data_t'(thr_pick));
      write_register(wpd_pkg::CFG_MIN_SPACING, wpd_pkg::cfg_data_t'(spc_pick));
      if ($urandom_range(0, 2) == 0)
        write_register(wpd_pkg::cfg_idx_t'($urandom_range(wpd_pkg::CFG_MIN_SPACING + 1,
                                                          CFG_IDX_TOP)),
                       wpd_pkg::cfg_data_t'($urandom));
      sender_steady = (phase % 3 == 1);
      phase_end     = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) play_waveform();
      phase++;
    end

    // drain
    in_if.valid = 1'b0;
    while (peak_results_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/wpd_pkg.sv
src/wpd_ifs.sv
src/wpd_cfg_regs.sv
src/wpd_step.sv
src/waveform_peak_detector_core.sv
dv/testbench.sv
